@@ rtl/gpio_mdi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO masked-data port: shared types and constants
// Function codes, register offsets and the request / response item layout.
// ----------------------------------------------------------------------------
package gpio_mdi_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_W = 12;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Register offsets, bits 1:0 ignored on compare
  localparam logic [ADDR_W-1:0] OFF_DIR = 12'h400;
  localparam logic [ADDR_W-1:0] OFF_IS  = 12'h404;
  localparam logic [ADDR_W-1:0] OFF_IBE = 12'h408;
  localparam logic [ADDR_W-1:0] OFF_IEV = 12'h40c;
  localparam logic [ADDR_W-1:0] OFF_IE  = 12'h410;
  localparam logic [ADDR_W-1:0] OFF_RIS = 12'h414;
  localparam logic [ADDR_W-1:0] OFF_MIS = 12'h418;
  localparam logic [ADDR_W-1:0] OFF_IC  = 12'h41c;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] pins_in;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rdata;
    logic [BYTE_W-1:0] pins_out;
    logic [BYTE_W-1:0] pins_oe;
    logic              irq;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/gpio_mdi_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO request channel
// Valid/ready channel carrying one bus access or pin sample tick per item.
// ----------------------------------------------------------------------------
interface gpio_mdi_req_if import gpio_mdi_pkg::*; ();

  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

@@ rtl/gpio_mdi_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO response channel
// Valid/ready channel carrying one result item per request.
// ----------------------------------------------------------------------------
interface gpio_mdi_rsp_if import gpio_mdi_pkg::*; ();

  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

@@ rtl/gpio_mdi_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO register file and event detector
// Holds the port state, applies one item when fire_i is high and presents
// the result computed from the updated state.
// ----------------------------------------------------------------------------
module gpio_mdi_core import gpio_mdi_pkg::*; #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  localparam int unsigned PW = PIN_COUNT;

  logic [PW-1:0] out_latch_q, out_latch_d;
  logic [PW-1:0] dir_q, dir_d;
  logic [PW-1:0] is_q, is_d;
  logic [PW-1:0] ibe_q, ibe_d;
  logic [PW-1:0] iev_q, iev_d;
  logic [PW-1:0] ie_q, ie_d;
  logic [PW-1:0] ris_q, ris_d;
  logic [PW-1:0] last_q, last_d;

  // Byte-wide fields resized to the pin count (zero fill or truncate)
  logic [PW+BYTE_W-1:0] wd_wide, ext_wide, msk_wide;
  logic [PW-1:0]        wd, ext, amask;

  logic [PW-1:0] level, rise, fall, edge_hit, active;
  logic [PW-1:0] rd;
  logic [PW+BYTE_W-1:0] rd_wide, ol_wide, dir_wide;
  logic [ADDR_W-1:0]    offs;
  logic                 data_sel;

  assign wd_wide  = {{PW{1'b0}}, req_i.wdata};
  assign ext_wide = {{PW{1'b0}}, req_i.pins_in};
  assign msk_wide = {{PW{1'b0}}, req_i.addr[BYTE_W+1:2]};
  assign wd       = wd_wide[PW-1:0];
  assign ext      = ext_wide[PW-1:0];
  assign amask    = msk_wide[PW-1:0];

  assign offs     = {req_i.addr[ADDR_W-1:2], 2'b00};
  assign data_sel = (offs < OFF_DIR);

  // Outputs read back their own driven value
  assign level    = (out_latch_q & dir_q) | (ext & ~dir_q);
  assign rise     = level & ~last_q;
  assign fall     = last_q & ~level;
  assign edge_hit = (ibe_q & (rise | fall)) |
                    (~ibe_q & ((iev_q & rise) | (~iev_q & fall)));
  assign active   = ~(level ^ iev_q);

  always_comb begin
    out_latch_d = out_latch_q;
    dir_d       = dir_q;
    is_d        = is_q;
    ibe_d       = ibe_q;
    iev_d       = iev_q;
    ie_d        = ie_q;
    ris_d       = ris_q;
    last_d      = last_q;
    rd          = '0;
    case (req_i.func)
      FUNC_READ: begin
        if (data_sel) begin
          rd = level & amask;
        end else begin
          case (offs)
            OFF_DIR: rd = dir_q;
            OFF_IS:  rd = is_q;
            OFF_IBE: rd = ibe_q;
            OFF_IEV: rd = iev_q;
            OFF_IE:  rd = ie_q;
            OFF_RIS: rd = ris_q;
            OFF_MIS: rd = ris_q & ie_q;
            default: rd = '0;
          endcase
        end
      end
      FUNC_WRITE: begin
        if (data_sel) begin
          out_latch_d = (out_latch_q & ~amask) | (wd & amask);
        end else begin
          case (offs)
            OFF_DIR: dir_d = wd;
            OFF_IS:  is_d  = wd;
            OFF_IBE: ibe_d = wd;
            OFF_IEV: iev_d = wd;
            OFF_IE:  ie_d  = wd;
            OFF_IC:  ris_d = ris_q & ~wd;
            default: ;
          endcase
        end
      end
      FUNC_TICK: begin
        // Edge bits are sticky; level bits follow the pin on every tick
        ris_d  = ((ris_q | edge_hit) & ~is_q) | (active & is_q);
        last_d = level;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_latch_q <= '0;
      dir_q       <= '0;
      is_q        <= '0;
      ibe_q       <= '0;
      iev_q       <= '0;
      ie_q        <= '0;
      ris_q       <= '0;
      last_q      <= '0;
    end else if (fire_i) begin
      out_latch_q <= out_latch_d;
      dir_q       <= dir_d;
      is_q        <= is_d;
      ibe_q       <= ibe_d;
      iev_q       <= iev_d;
      ie_q        <= ie_d;
      ris_q       <= ris_d;
      last_q      <= last_d;
    end
  end

  assign rd_wide  = {{BYTE_W{1'b0}}, rd};
  assign ol_wide  = {{BYTE_W{1'b0}}, out_latch_d};
  assign dir_wide = {{BYTE_W{1'b0}}, dir_d};

  assign rsp_o.rdata    = rd_wide[BYTE_W-1:0];
  assign rsp_o.pins_out = ol_wide[BYTE_W-1:0];
  assign rsp_o.pins_oe  = dir_wide[BYTE_W-1:0];
  assign rsp_o.irq      = |(ris_d & ie_d);

endmodule
`default_nettype wire

@@ rtl/gpio_port_masked_data_irq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// GPIO port with masked data addressing and per-pin interrupts
// Top level: input register, register file / event detector, result register.
// ----------------------------------------------------------------------------
// Each request item is a bus read, a bus write or a pin sample tick, and
// produces exactly one response item computed from the state after the item
// is applied. The port sustains one item per clock while responses are taken:
// a request is captured in an input register, then applied to the register
// file, and the result lands in an output register. The input side keeps
// accepting while a finished response waits, as long as the result register
// is free or being drained in the same cycle; the only stall is a full input
// register behind a response that is not taken. Data offsets below 0x400 use
// address bits 9:2 as the pin mask; control registers sit at 0x400..0x41C,
// and everything from 0x420 up reads as zero and ignores writes.
module gpio_port_masked_data_irq import gpio_mdi_pkg::*; #(
  parameter int unsigned PIN_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gpio_mdi_req_if.sink   req_i,
  gpio_mdi_rsp_if.source rsp_o
);

  req_t req_q;
  logic in_valid_q;
  rsp_t rsp_q, rsp_d;
  logic out_valid_q;
  logic advance;
  logic in_take;

  // Apply the held item when the result register is empty or being drained
  assign advance     = in_valid_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = ~in_valid_q | advance;
  assign in_take     = req_i.valid & req_i.ready;

  // Hold the incoming item; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  gpio_mdi_core #(
    .PIN_COUNT (PIN_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // A stall on the input only comes from a full pipe behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (in_valid_q && out_valid_q && !rsp_o.ready))
    else $error("input stalled without a blocked result");

  // An applied item always leaves a result behind
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after advance");

  // An accepted item is held in the input register
  a_take_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted item lost");

  // A held item that is not applied stays unchanged
  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(req_q)))
    else $error("held item changed while stalled");

  // A drained result with nothing behind it empties the result register
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rsp_o.ready && !advance) |=> !out_valid_q)
    else $error("result repeated after being taken");

endmodule
`default_nettype wire
